// ===== rtl/pngunf_pkg.sv =====
// ----------------------------------------------------------------------------
// pngunf_pkg
// Shared types and constants of the PNG scanline unfilter unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pngunf_pkg;

  localparam int BYTE_W      = 8;
  localparam int ROW_LEN_W   = 13;
  localparam int BPP_CFG_W   = 4;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 8'd1;

  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET      = 13'd1;
  localparam logic [BPP_CFG_W-1:0] BYTES_PER_PIXEL_RESET = 4'd1;

  localparam logic [BYTE_W-1:0] FILTER_CODE_MAX = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

endpackage

`default_nettype wire

// ===== rtl/png_scanline_unfilter_unit.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit
// PNG scanline reconstruction: one filtered byte in, one raw byte out.
// ----------------------------------------------------------------------------
// The unit takes one filtered byte per cycle and returns one reconstructed
// byte per cycle while the output is not stalled, through stage 1 and the
// output register. The rate is set by the line store, a single memory with
// one read port and one write port: the above byte is read on accept and
// the raw byte is written back when stage 1 advances, with forwarding when
// both hit the same entry. Filter type and image start travel in s_tuser;
// the row end flag comes out on m_tlast. Configuration writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter_unit #(
  parameter int MAX_ROW_BYTES = 4096,
  parameter int MAX_BPP       = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pngunf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pngunf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [7:0]                         s_tdata,  // [7:0] filtered_byte
  input  wire logic [8:0]                         s_tuser,  // [7:0] filter_type, [8] image_start
  // output stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [7:0]                              m_tdata,  // [7:0] raw_byte
  output logic                                    m_tlast   // row_end
);

  localparam int POS_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int BPP_W  = $clog2(MAX_BPP + 1);
  localparam int HIDX_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

  // configuration registers
  logic [pngunf_pkg::ROW_LEN_W-1:0] row_length;
  logic [pngunf_pkg::BPP_CFG_W-1:0] bytes_per_pixel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length      <= pngunf_pkg::ROW_LENGTH_RESET;
      bytes_per_pixel <= pngunf_pkg::BYTES_PER_PIXEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pngunf_pkg::REG_ROW_LENGTH) begin
        row_length <= cfg_data[pngunf_pkg::ROW_LEN_W-1:0];
      end else if (cfg_index == pngunf_pkg::REG_BYTES_PER_PIXEL) begin
        bytes_per_pixel <= cfg_data[pngunf_pkg::BPP_CFG_W-1:0];
      end
    end
  end

  // clamped configuration
  logic [LEN_W-1:0] len_c;
  logic [BPP_W-1:0] bpp_c;

  always_comb begin
    if (row_length == '0) begin
      len_c = LEN_W'(1);
    end else if (32'(row_length) > 32'(MAX_ROW_BYTES)) begin
      len_c = LEN_W'(MAX_ROW_BYTES);
    end else begin
      len_c = LEN_W'(row_length);
    end
    if (bytes_per_pixel == '0) begin
      bpp_c = BPP_W'(1);
    end else if (32'(bytes_per_pixel) > 32'(MAX_BPP)) begin
      bpp_c = BPP_W'(MAX_BPP);
    end else begin
      bpp_c = BPP_W'(bytes_per_pixel);
    end
  end

  // row tracking state
  logic [POS_W-1:0]    byte_position;
  logic [POS_W-1:0]    byte_position_next;
  logic                first_row;
  logic                first_row_next;
  pngunf_pkg::filter_t row_filter;
  pngunf_pkg::filter_t row_filter_next;

  // stage 1 registers
  logic                s1_valid;
  logic [7:0]          s1_fb;
  logic [POS_W-1:0]    s1_pos;
  pngunf_pkg::filter_t s1_filt;
  logic                s1_first_row;
  logic [BPP_W-1:0]    s1_bpp;
  logic                s1_last;
  logic                fwd_hit;
  logic [7:0]          fwd_data;
  logic [7:0]          mem_rdata;

  logic [7:0] line_store [MAX_ROW_BYTES];
  logic [7:0] left_history  [MAX_BPP];
  logic [7:0] above_history [MAX_BPP];

  logic s_accept;
  logic s1_adv;
  logic s1_write;

  assign s1_adv   = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_adv;
  assign s_accept = s_tvalid && s_tready;
  assign s1_write = s1_valid && s1_adv;

  // stage 0: position, filter latch, row end
  logic [POS_W-1:0]    pos0;
  logic [POS_W-1:0]    pos_c;
  logic                fr0;
  logic                last0;
  pngunf_pkg::filter_t filt0;

  always_comb begin
    pos0 = s_tuser[8] ? '0 : byte_position;
    fr0  = s_tuser[8] ? 1'b1 : first_row;
    if (32'(pos0) >= 32'(len_c)) begin
      pos_c = POS_W'(len_c - LEN_W'(1));
    end else begin
      pos_c = pos0;
    end
    if (pos_c == '0) begin
      if (s_tuser[7:0] <= pngunf_pkg::FILTER_CODE_MAX) begin
        filt0 = pngunf_pkg::filter_t'(s_tuser[2:0]);
      end else begin
        filt0 = pngunf_pkg::FILT_NONE;
      end
    end else begin
      filt0 = row_filter;
    end
    last0 = (32'(pos_c) + 32'd1) >= 32'(len_c);

    byte_position_next = byte_position;
    first_row_next     = first_row;
    row_filter_next    = row_filter;
    if (s_accept) begin
      row_filter_next = filt0;
      if (last0) begin
        byte_position_next = '0;
        first_row_next     = 1'b0;
      end else begin
        byte_position_next = pos_c + POS_W'(1);
        first_row_next     = fr0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      first_row     <= 1'b1;
      row_filter    <= pngunf_pkg::FILT_NONE;
    end else begin
      byte_position <= byte_position_next;
      first_row     <= first_row_next;
      row_filter    <= row_filter_next;
    end
  end

  // stage 1: predictor and reconstruction
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [7:0] pred;
  logic [7:0] raw;
  logic signed [9:0] pa;
  logic signed [9:0] pb;
  logic signed [9:0] pc;
  logic [8:0] avg_sum;

  always_comb begin
    if (s1_first_row) begin
      b = '0;
    end else if (fwd_hit) begin
      b = fwd_data;
    end else begin
      b = mem_rdata;
    end
    if (32'(s1_pos) >= 32'(s1_bpp)) begin
      a = left_history[HIDX_W'(s1_bpp - BPP_W'(1))];
      c = above_history[HIDX_W'(s1_bpp - BPP_W'(1))];
    end else begin
      a = '0;
      c = '0;
    end
    pa = 10'(signed'({2'b00, b})) - 10'(signed'({2'b00, c}));
    pb = 10'(signed'({2'b00, a})) - 10'(signed'({2'b00, c}));
    pc = pa + pb;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    avg_sum = {1'b0, a} + {1'b0, b};
    case (s1_filt)
      pngunf_pkg::FILT_SUB:   pred = a;
      pngunf_pkg::FILT_UP:    pred = b;
      pngunf_pkg::FILT_AVG:   pred = avg_sum[8:1];
      pngunf_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:                pred = '0;
    endcase
    raw = s1_fb + pred;
  end

  // line store: read on accept, write back from stage 1
  always_ff @(posedge clk) begin
    if (s1_write) begin
      line_store[s1_pos] <= raw;
    end
    if (s_accept) begin
      mem_rdata <= line_store[pos_c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_write && (s1_pos == pos_c);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_fb        <= s_tdata;
      s1_pos       <= pos_c;
      s1_filt      <= filt0;
      s1_first_row <= fr0;
      s1_bpp       <= bpp_c;
      s1_last      <= last0;
      fwd_data     <= raw;
    end
  end

  // pixel history: shift on every reconstructed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_BPP; k++) begin
        left_history[k]  <= '0;
        above_history[k] <= '0;
      end
    end else if (s1_write) begin
      for (int k = MAX_BPP - 1; k > 0; k--) begin
        left_history[k]  <= left_history[k-1];
        above_history[k] <= above_history[k-1];
      end
      left_history[0]  <= raw;
      above_history[0] <= b;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      m_tdata <= raw;
      m_tlast <= s1_last;
    end
  end

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !s_tready)
    else $error("input taken while stage 1 is stalled");

  a_accept_drains_stage1: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s1_valid) |-> s1_write)
    else $error("input taken while stage 1 holds an item");

  a_row_end_wraps: assert property (@(posedge clk) disable iff (rst)
    (s_accept && last0) |=> (byte_position == '0 && !first_row))
    else $error("row end did not reset the position");

  a_image_start_first_row: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tuser[8] && !last0) |=> first_row)
    else $error("image start did not enter first-row mode");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PNG scanline unfilter unit.
// ----------------------------------------------------------------------------
// Streams filtered bytes through the unit with random gaps and back-pressure
// and rebuilds every raw byte in a cycle-free model of the row, left and
// upper-left history. Row length and pixel size are reprogrammed between
// batches, the extremes included; after the row length outgrows the written line store
// entries, a new image opens so that only written entries are read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class unfilter_tracker;

  localparam int ROW_CAP = 4096;
  localparam int BPP_CAP = 8;

  typedef struct packed {
    logic [7:0] raw;
    logic       row_end;
  } raw_item_t;

  logic [7:0]          prev_row [ROW_CAP];
  logic [7:0]          left_hist [BPP_CAP];
  logic [7:0]          above_hist [BPP_CAP];
  int unsigned         byte_pos;
  pngunf_pkg::filter_t row_filter;
  bit                  first_row;
  logic [12:0]         row_len;
  logic [3:0]          bpp_reg;
  int unsigned         store_hi;
  int unsigned         faults;
  raw_item_t           raw_due [$];

  function new();
    foreach (left_hist[k]) begin
      left_hist[k]  = '0;
      above_hist[k] = '0;
    end
    byte_pos   = 0;
    row_filter = pngunf_pkg::FILT_NONE;
    first_row  = 1'b1;
    row_len    = pngunf_pkg::ROW_LENGTH_RESET;
    bpp_reg    = pngunf_pkg::BYTES_PER_PIXEL_RESET;
    store_hi   = 0;
    faults     = 0;
  endfunction

  function int unsigned eff_len();
    if (row_len == 0) return 1;
    if (row_len > ROW_CAP) return ROW_CAP;
    return row_len;
  endfunction

  function int unsigned eff_bpp();
    if (bpp_reg == 0) return 1;
    if (bpp_reg > BPP_CAP) return BPP_CAP;
    return bpp_reg;
  endfunction

  function bit row_opens();
    return byte_pos == 0 || byte_pos >= eff_len() - 1 && eff_len() == 1;
  endfunction

  function bit needs_restart();
    return !first_row && eff_len() > store_hi;
  endfunction

  function void write_reg(logic [7:0] idx, logic [12:0] val);
    if (idx == pngunf_pkg::REG_ROW_LENGTH) begin
      row_len = val;
    end else if (idx == pngunf_pkg::REG_BYTES_PER_PIXEL) begin
      bpp_reg = val[3:0];
    end
  endfunction

  function logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    int p, da, db, dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p >= int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p >= int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p >= int'(c)) ? p - int'(c) : int'(c) - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  function void take_filtered(logic [7:0] fb, logic [7:0] ft, logic st);
    int unsigned len, bpp, p;
    logic [7:0]  a, b, c, pred, raw;
    logic [8:0]  sum9;
    bit          last;
    len = eff_len();
    bpp = eff_bpp();
    if (st) begin
      byte_pos  = 0;
      first_row = 1'b1;
    end
    p = (byte_pos >= len) ? len - 1 : byte_pos;
    if (p == 0) begin
      row_filter = (ft <= pngunf_pkg::FILTER_CODE_MAX) ?
                   pngunf_pkg::filter_t'(ft[2:0]) : pngunf_pkg::FILT_NONE;
    end
    a = '0;
    b = '0;
    c = '0;
    if (!first_row) b = prev_row[p];
    if (p >= bpp) begin
      a = left_hist[bpp-1];
      c = above_hist[bpp-1];
    end
    case (row_filter)
      pngunf_pkg::FILT_SUB:   pred = a;
      pngunf_pkg::FILT_UP:    pred = b;
      pngunf_pkg::FILT_AVG: begin
        sum9 = {1'b0, a} + {1'b0, b};
        pred = sum9[8:1];
      end
      pngunf_pkg::FILT_PAETH: pred = paeth(a, b, c);
      default:                pred = '0;
    endcase
    raw = fb + pred;
    for (int k = BPP_CAP - 1; k > 0; k--) begin
      left_hist[k]  = left_hist[k-1];
      above_hist[k] = above_hist[k-1];
    end
    left_hist[0]  = raw;
    above_hist[0] = b;
    prev_row[p]   = raw;
    if (p + 1 > store_hi) store_hi = p + 1;
    last = (p + 1 >= len);
    if (last) begin
      byte_pos  = 0;
      first_row = 1'b0;
    end else begin
      byte_pos = p + 1;
    end
    raw_due.push_back('{raw: raw, row_end: last});
  endfunction

  function void match_raw(logic [7:0] raw, logic row_end);
    raw_item_t want;
    if (raw_due.size() == 0) begin
      $error("raw_byte: output item %0d with none pending", raw);
      faults++;
      return;
    end
    want = raw_due.pop_front();
    if (raw !== want.raw) begin
      $error("raw_byte: expected %0d, actual %0d", want.raw, raw);
      faults++;
    end
    if (row_end !== want.row_end) begin
      $error("row_end: expected %0d, actual %0d", want.row_end, row_end);
      faults++;
    end
  endfunction

endclass

module tb;

  localparam int RANDOM_ITEMS = 1930;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 80;

  localparam logic [7:0] CODE_UNKNOWN_LO = pngunf_pkg::FILTER_CODE_MAX + 8'd1;
  localparam logic [7:0] CODE_UNKNOWN_HI = 8'hFF;

  logic                               clk;
  logic                               rst;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [pngunf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pngunf_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [7:0]                         s_tdata;  // [7:0] filtered_byte
  logic [8:0]                         s_tuser;  // [7:0] filter_type, [8] image_start
  logic                               m_tvalid;
  logic                               m_tready;
  logic [7:0]                         m_tdata;  // [7:0] raw_byte
  logic                               m_tlast;  // row_end

  int in_gap_pct;
  int out_gap_pct;
  int hold_req;
  unfilter_tracker sb = new();

  png_scanline_unfilter_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    int held;
    held     = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        held     = hold_req;
        hold_req = 0;
      end
      if (held > 0) begin
        m_tready <= 1'b0;
        held--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= out_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.match_raw(m_tdata, m_tlast);
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("status: fail");
    $finish;
  end

  task automatic load_regs(input bit do_len, input int unsigned len,
                           input bit do_bpp, input int unsigned bpp);
    for (int r = 0; r < 2; r++) begin
      if (r == 0 ? !do_len : !do_bpp) continue;
      cfg_valid <= 1'b1;
      cfg_index <= (r == 0) ? pngunf_pkg::REG_ROW_LENGTH : pngunf_pkg::REG_BYTES_PER_PIXEL;
      cfg_data  <= pngunf_pkg::CFG_DATA_W'((r == 0) ? len : bpp);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg((r == 0) ? pngunf_pkg::REG_ROW_LENGTH : pngunf_pkg::REG_BYTES_PER_PIXEL,
                   pngunf_pkg::CFG_DATA_W'((r == 0) ? len : bpp));
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] fb, input logic [7:0] ft, input logic st);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= fb;
    s_tuser  <= {st, ft};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_filtered(fb, ft, st);
    @(negedge clk);
  endtask

  task automatic run_items(input int n, input bit restart);
    logic [7:0] fb, ft;
    logic       st;
    bit         opens;
    for (int i = 0; i < n; i++) begin
      opens = sb.row_opens();
      if (i == 0 && restart) begin
        st = 1'b1;
      end else begin
        st = opens ? ($urandom_range(0, 24) == 0) : ($urandom_range(0, 299) == 0);
      end
      if (opens || st) begin
        ft = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                                           8'($urandom_range(0, pngunf_pkg::FILTER_CODE_MAX));
      end else begin
        ft = 8'($urandom);
      end
      case ($urandom_range(0, 9))
        0:       fb = 8'h00;
        1:       fb = 8'hFF;
        default: fb = 8'($urandom);
      endcase
      send_byte(fb, ft, st);
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic settle();
    while (sb.raw_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int          sent, phase, n;
    int unsigned len, bpp;
    logic [7:0]  code;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    in_gap_pct  = 32;
    out_gap_pct = 32;
    hold_req    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_regs(1'b1, 3, 1'b1, 2);
    for (int r = 0; r < 7; r++) begin
      case (r)
        0:       code = 8'(pngunf_pkg::FILT_NONE);
        1:       code = 8'(pngunf_pkg::FILT_SUB);
        2:       code = 8'(pngunf_pkg::FILT_UP);
        3:       code = 8'(pngunf_pkg::FILT_AVG);
        4:       code = 8'(pngunf_pkg::FILT_PAETH);
        5:       code = CODE_UNKNOWN_LO;
        default: code = CODE_UNKNOWN_HI;
      endcase
      for (int k = 0; k < 3; k++) begin
        send_byte((k == 0) ? 8'hFF : (k == 1) ? 8'h00 : 8'(37 * r + 90), code, r == 0 && k == 0);
      end
    end
    send_byte(8'h5A, 8'(pngunf_pkg::FILT_SUB), 1'b0);
    send_byte(8'hC3, 8'(pngunf_pkg::FILT_UP), 1'b1);
    s_tvalid <= 1'b0;

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      in_gap_pct  = 32;
      out_gap_pct = 32;
      n           = $urandom_range(8, 90);
      if (phase < 5) begin
        case (phase)
          0:       begin len = 0;    bpp = 0;  end
          1:       begin len = 8191; bpp = 15; end
          2:       begin len = 17;   bpp = 8;  end
          3:       begin len = 4096; bpp = 1;  end
          default: begin len = 1;    bpp = 8;  end
        endcase
        load_regs(1'b1, len, 1'b1, bpp);
      end else if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 19))
          0:       len = 0;
          1:       len = 1;
          2:       len = 4096;
          3:       len = $urandom_range(4097, 8191);
          4, 5, 6: len = $urandom_range(25, 64);
          default: len = $urandom_range(2, 24);
        endcase
        case ($urandom_range(0, 7))
          0:       bpp = 0;
          1:       bpp = $urandom_range(9, 15);
          default: bpp = $urandom_range(1, 8);
        endcase
        load_regs($urandom_range(0, 2) != 0, len, $urandom_range(0, 2) != 0, bpp);
      end
      if (phase == 2) begin
        n           = 250;
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end
      if (phase == 4 || phase == 9) begin
        hold_req   = HOLD_CYCLES;
        in_gap_pct = 0;
      end
      run_items(n, sb.needs_restart());
      sent += n;
      phase++;
    end

    settle();
    if (sb.faults == 0 && sb.raw_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pngunf_pkg.sv
rtl/png_scanline_unfilter_unit.sv
verif/tb.sv
